### rtl/zcz_pkg.sv
// Shared widths, constants and helper functions of the ZCZ pair checker.
`default_nettype none

package zcz_pkg;

  // Width of one input sequence in chips.
  localparam int SEQ_W = 64;
  // Width of a sequence with its first period repeated behind it.
  localparam int DBL_W = 2 * SEQ_W;
  // Mismatch vectors of both sequences are counted in chunks of this width.
  localparam int CHUNK_W = 8;
  localparam int NUM_CHUNK = DBL_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);

  // Configuration register and result field widths.
  localparam int CFG_W = 7;
  localparam int OZ_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Out-of-zone magnitude that marks an optimal pair.
  localparam logic signed [OZ_W-1:0] OPT_MAG = 9'sd2;

  // Stream payload widths, whole bytes.
  localparam int IN_TDATA_W = 2 * SEQ_W;
  localparam int OUT_FIELD_W = 2 + OZ_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Number of set bits in one chunk.
  function automatic logic [CHUNK_CNT_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] v);
    logic [CHUNK_CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      c = c + CHUNK_CNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/zcz_pair_checker_top.sv
// An accepted input beat passes through five stage registers, each holding one pair, to the output.
// Throughput: one sequence pair per cycle while the output does not stall.
// The slowest stage sums sixteen chunk counts per shift lane; all other stages are shallower.
// Reset clears every stage valid bit and sets the sequence length register to 64.
// Stalls propagate back stage by stage, so empty stages keep accepting beats.
`default_nettype none

module zcz_pair_checker_top
  import zcz_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // Configuration: sequence length register.
  input  wire                    cfg_we_i,
  input  wire  [CFG_W-1:0]       cfg_wdata_i,
  // Input stream. tdata fields from bit 0 up: seq_a[63:0], seq_b[63:0].
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Output stream. tdata fields from bit 0 up: is_optimal, zone_clear,
  // out_zone_sum[8:0], zero padding.
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(2 * MAX_LEN + 1);
  localparam int NUM_SHIFT = MAX_LEN / 2;
  localparam int DIFF_W = OZ_W + 1;

  // Mask of chip positions below the given length.
  function automatic logic [SEQ_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({SEQ_W{1'b1}} << len);
  endfunction

  // Configuration register.
  logic [CFG_W-1:0] cfg_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  // Effective length: zero means one, values above MAX_LEN saturate.
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    priority if (cfg_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_len_q > CFG_W'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(cfg_len_q);
    end
  end

  // Stage valid bits and backpressure chain.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: capture the pair and the effective length.
  logic [SEQ_W-1:0] a1_q, b1_q;
  logic [LEN_W-1:0] len1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a1_q   <= s_axis_tdata_i[SEQ_W-1:0];
      b1_q   <= s_axis_tdata_i[2*SEQ_W-1:SEQ_W];
      len1_q <= eff_len;
    end
  end

  // Stage 2: mask chips beyond L and append a second period, so that a
  // cyclic shift becomes a plain slice.
  logic [SEQ_W-1:0] am, bm;
  logic [DBL_W-1:0] a2_d, b2_d;
  logic [DBL_W-1:0] a2_q, b2_q;
  logic [LEN_W-1:0] len2_q;

  always_comb begin
    am   = a1_q & len_mask(len1_q);
    bm   = b1_q & len_mask(len1_q);
    a2_d = {{SEQ_W{1'b0}}, am} | ({{SEQ_W{1'b0}}, am} << len1_q);
    b2_d = {{SEQ_W{1'b0}}, bm} | ({{SEQ_W{1'b0}}, bm} << len1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      a2_q   <= a2_d;
      b2_q   <= b2_d;
      len2_q <= len1_q;
    end
  end

  // Stage 3: per shift lane, mismatch vectors of both sequences and their
  // chunk-wise bit counts.
  logic [CHUNK_CNT_W-1:0] chunk3_d [NUM_SHIFT][NUM_CHUNK];
  logic [CHUNK_CNT_W-1:0] chunk3_q [NUM_SHIFT][NUM_CHUNK];
  logic [LEN_W-1:0]       len3_q;

  always_comb begin
    logic [SEQ_W-1:0] mask;
    logic [DBL_W-1:0] mism;
    mask = len_mask(len2_q);
    for (int k = 0; k < NUM_SHIFT; k++) begin
      mism[SEQ_W-1:0]     = (a2_q[k+1 +: SEQ_W] ^ a2_q[SEQ_W-1:0]) & mask;
      mism[DBL_W-1:SEQ_W] = (b2_q[k+1 +: SEQ_W] ^ b2_q[SEQ_W-1:0]) & mask;
      for (int c = 0; c < NUM_CHUNK; c++) begin
        chunk3_d[k][c] = popcount_chunk(mism[c*CHUNK_W +: CHUNK_W]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      chunk3_q <= chunk3_d;
      len3_q   <= len2_q;
    end
  end

  // Stage 4: total mismatch count of both sequences per shift lane.
  logic [CNT_W-1:0] tot4_d [NUM_SHIFT];
  logic [CNT_W-1:0] tot4_q [NUM_SHIFT];
  logic [LEN_W-1:0] len4_q;

  always_comb begin
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    for (int k = 0; k < NUM_SHIFT; k++) begin
      lo = '0;
      hi = '0;
      for (int c = 0; c < NUM_CHUNK / 2; c++) begin
        lo = lo + CNT_W'(chunk3_q[k][c]);
        hi = hi + CNT_W'(chunk3_q[k][c + NUM_CHUNK / 2]);
      end
      tot4_d[k] = lo + hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      tot4_q <= tot4_d;
      len4_q <= len3_q;
    end
  end

  // Stage 5: the summed correlation at a shift is 2L - 2 * mismatches, so it
  // is zero exactly when the mismatch count equals L.
  logic [LEN_W-1:0]        zone;
  logic [CNT_W-1:0]        zone_tot;
  logic                    clear5_d;
  logic [DIFF_W-1:0]       diff;
  logic signed [OZ_W-1:0]  oz5_d;
  logic                    opt5_d;
  logic                    clear5_q, opt5_q;
  logic signed [OZ_W-1:0]  oz5_q;

  always_comb begin
    zone     = len4_q >> 1;
    zone_tot = '0;
    clear5_d = 1'b1;
    for (int k = 0; k < NUM_SHIFT; k++) begin
      if (LEN_W'(k + 1) == zone) begin
        zone_tot = tot4_q[k];
      end
      if (LEN_W'(k + 1) < zone && tot4_q[k] != CNT_W'(len4_q)) begin
        clear5_d = 1'b0;
      end
    end
    diff   = (DIFF_W'(len4_q) << 1) - (DIFF_W'(zone_tot) << 1);
    oz5_d  = signed'(diff[OZ_W-1:0]);
    opt5_d = clear5_d && (oz5_d == OPT_MAG || oz5_d == -OPT_MAG);
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      clear5_q <= clear5_d;
      opt5_q   <= opt5_d;
      oz5_q    <= oz5_d;
    end
  end

  // Output beat.
  assign m_axis_tvalid_o = v5_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, oz5_q, clear5_q, opt5_q};

`ifndef SYNTH
  // An accepted beat always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted beat did not reach stage 1");

  // The carried length stays within one to MAX_LEN.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (len1_q >= LEN_W'(1) && len1_q <= LEN_W'(MAX_LEN)))
    else $error("effective length out of range");

  // An optimal verdict needs a clear zone.
  a_opt_needs_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!opt5_q || clear5_q))
    else $error("optimal verdict without a clear zone");

  // The out-of-zone sum is always even.
  a_oz_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !oz5_q[0])
    else $error("odd out-of-zone sum");
`endif

endmodule

`default_nettype wire

### tb/zcz_pair_checker_top_tb.sv
// Self-checking testbench for the ZCZ complementary pair checker stream pipeline.
`timescale 1ns / 1ps

module zcz_pair_checker_top_tb
  import zcz_pkg::*;
();

  localparam int SEQ_MAX_LEN = 64;
  localparam int NUM_DIRECTED = 18;
  localparam int NUM_PHASES = 14;
  localparam int PHASE_PAIRS = 80;
  localparam int CALM_PAIRS = 120;

  // One verdict as it sits in the low bits of the result beat, is_optimal at bit 0.
  typedef struct packed {
    logic signed [OZ_W-1:0] oz_sum;
    logic                   zone_clear;
    logic                   is_optimal;
  } zcz_verdict_t;

  // One directed pair; a typed verdict is used where has_verdict is set.
  typedef struct packed {
    logic [CFG_W-1:0] len_cfg;
    logic [SEQ_W-1:0] seq_a;
    logic [SEQ_W-1:0] seq_b;
    logic             has_verdict;
    zcz_verdict_t     verdict;
  } pair_case_t;

  localparam pair_case_t DIRECTED_PAIRS [NUM_DIRECTED] = '{
    // Constant, alternating, half-period and ramp sequences at full length.
    '{7'd64, 64'h0, 64'h0, 1'b1, '{9'sd128, 1'b0, 1'b0}},
    '{7'd64, '1, '1, 1'b1, '{9'sd128, 1'b0, 1'b0}},
    '{7'd64, '1, 64'h0, 1'b1, '{9'sd128, 1'b0, 1'b0}},
    '{7'd64, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 1'b1,
      '{-9'sd128, 1'b0, 1'b0}},
    '{7'd64, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{7'd64, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    // A length of zero acts as length one: empty zone, sum 2 at shift zero.
    '{7'd0, 64'hDEAD_BEEF_0BAD_F00D, 64'h1234_5678_9ABC_DEF0, 1'b1,
      '{9'sd2, 1'b1, 1'b1}},
    '{7'd1, '1, 64'h0, 1'b1, '{9'sd2, 1'b1, 1'b1}},
    // Length two: empty zone, chips above the length are junk.
    '{7'd2, 64'hFFFF_FFFF_FFFF_FFF3, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1,
      '{9'sd0, 1'b1, 1'b0}},
    '{7'd2, 64'h0, 64'h0, 1'b1, '{9'sd4, 1'b1, 1'b0}},
    // Length three: optimal pairs with both signs of the out-of-zone sum, then one that is not optimal.
    '{7'd3, 64'h7, 64'h3, 1'b1, '{9'sd2, 1'b1, 1'b1}},
    '{7'd3, 64'h1, 64'h1, 1'b1, '{-9'sd2, 1'b1, 1'b1}},
    '{7'd3, 64'h0, 64'h0, 1'b1, '{9'sd6, 1'b1, 1'b0}},
    // Complementary pairs of length four and eight clear the zone, then a length-five pair.
    '{7'd4, 64'h7, 64'hB, 1'b1, '{9'sd0, 1'b1, 1'b0}},
    '{7'd8, 64'hB7, 64'h47, 1'b0, '0},
    '{7'd5, 64'hFFFF_FFFF_FFFF_FFE5, 64'h0000_0000_0000_0019, 1'b0, '0},
    // Lengths above the maximum saturate to 64.
    '{7'd127, 64'h0, 64'h0, 1'b1, '{9'sd128, 1'b0, 1'b0}},
    '{7'd65, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000, 1'b1,
      '{-9'sd128, 1'b0, 1'b0}}
  };

  localparam logic [CFG_W-1:0] PHASE_LENGTHS [12] = '{
    7'd3, 7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd0, 7'd127, 7'd65, 7'd6, 7'd10
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Length register as the block should hold it.
  logic [CFG_W-1:0] seq_len_reg = CFG_RESET;
  zcz_verdict_t     pending_verdicts [$];
  zcz_verdict_t     want_v;
  zcz_verdict_t     got_v;
  int               fail_count = 0;
  int               src_gap_pct = 10;
  int               sink_stall_pct = 10;

  zcz_pair_checker_top #(
    .MAX_LEN(SEQ_MAX_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends one expected verdict behind the ones still in flight.
  function automatic void enqueue_verdict(input zcz_verdict_t v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // Length in chips after the zero and saturation rules.
  function automatic int eff_len(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) return 1;
    if (int'(cfg) > SEQ_MAX_LEN) return SEQ_MAX_LEN;
    return int'(cfg);
  endfunction

  function automatic logic [SEQ_W-1:0] len_mask(input int len);
    if (len >= SEQ_W) return '1;
    return (64'd1 << len) - 64'd1;
  endfunction

  // Periodic autocorrelation of one sequence at shift u.
  function automatic int cyclic_corr(input logic [SEQ_W-1:0] s, input int u, input int len);
    int acc;
    acc = 0;
    for (int i = 0; i < len; i++) begin
      acc += (s[i] == s[(i + u) % len]) ? 1 : -1;
    end
    return acc;
  endfunction

  // Expected verdict for one pair at the given length register value.
  function automatic zcz_verdict_t screen_pair(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b,
                                               input logic [CFG_W-1:0] cfg);
    zcz_verdict_t v;
    int           len;
    int           zone;
    int           oz;
    len = eff_len(cfg);
    zone = len / 2;
    v.zone_clear = 1'b1;
    for (int u = 1; u < zone; u++) begin
      if (cyclic_corr(a, u, len) + cyclic_corr(b, u, len) != 0) v.zone_clear = 1'b0;
    end
    oz = cyclic_corr(a, zone, len) + cyclic_corr(b, zone, len);
    v.oz_sum = OZ_W'(oz);
    // An optimal pair has a magnitude of exactly two outside the zone.
    v.is_optimal = v.zone_clear && (oz == 2 || oz == -2);
    return v;
  endfunction

  // Complementary pair of a power-of-two length, built by concatenation.
  function automatic void golay_pair(input int len, output logic [SEQ_W-1:0] a,
                                     output logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] a_next;
    a = 64'd1;
    b = 64'd1;
    for (int n = 1; n < len; n = n * 2) begin
      a_next = a | (b << n);
      b = a | ((~b & len_mask(n)) << n);
      a = a_next;
    end
  endfunction

  // Rotate, maybe reverse, maybe negate; none of these changes the autocorrelation.
  // Chips above the length are filled with junk.
  function automatic logic [SEQ_W-1:0] scramble_seq(input logic [SEQ_W-1:0] s, input int len);
    logic [SEQ_W-1:0] m;
    logic [SEQ_W-1:0] r;
    logic [SEQ_W-1:0] t;
    int               rot;
    m = len_mask(len);
    rot = $urandom_range(0, len - 1);
    r = '0;
    for (int i = 0; i < len; i++) r[(i + rot) % len] = s[i];
    if ($urandom_range(0, 1) == 1) begin
      t = '0;
      for (int i = 0; i < len; i++) t[i] = r[len - 1 - i];
      r = t;
    end
    if ($urandom_range(0, 1) == 1) r = ~r & m;
    return r | ({$urandom, $urandom} & ~m);
  endfunction

  // Drives one beat on the input side and records its verdict once accepted.
  task automatic push_pair(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
                           input logic has_verdict, input zcz_verdict_t verdict);
    if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tdata_i <= {b, a};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    enqueue_verdict(has_verdict ? verdict : screen_pair(a, b, seq_len_reg));
    @(negedge clk_i);
  endtask

  // Lets the pipeline drain, then writes the length register.
  task automatic set_length(input logic [CFG_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    seq_len_reg = value;
  endtask

  // Random pairs at one length: complementary pairs in disguise, plain patterns, noise.
  task automatic run_phase(input logic [CFG_W-1:0] cfg, input int count);
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic [SEQ_W-1:0] m;
    logic [SEQ_W-1:0] t;
    int               len;
    int               pick;
    set_length(cfg);
    len = eff_len(cfg);
    m = len_mask(len);
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && (len & (len - 1)) == 0) begin
        golay_pair(len, a, b);
        a = scramble_seq(a, len);
        b = scramble_seq(b, len);
        if ($urandom_range(0, 1) == 1) begin
          t = a;
          a = b;
          b = t;
        end
      end else if (pick < 6) begin
        case ($urandom_range(0, 3))
          0: t = '0;
          1: t = '1;
          2: t = 64'h5555_5555_5555_5555;
          default: t = 64'h0000_0000_FFFF_FFFF;
        endcase
        a = (t & m) | ({$urandom, $urandom} & ~m);
        b = (($urandom_range(0, 1) == 1 ? t : ~t) & m) | ({$urandom, $urandom} & ~m);
      end else begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end
      push_pair(a, b, 1'b0, '0);
    end
  endtask

  // Output side: ready drops in random bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compare every result beat against the oldest pending verdict.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_v = zcz_verdict_t'(m_axis_tdata_o[OUT_FIELD_W-1:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no pending pair: tdata %h", m_axis_tdata_o);
        fail_count++;
      end else begin
        want_v = pending_verdicts.pop_front();
        if (got_v.is_optimal !== want_v.is_optimal) begin
          $error("is_optimal: expected %0d, actual %0d", want_v.is_optimal, got_v.is_optimal);
          fail_count++;
        end
        if (got_v.zone_clear !== want_v.zone_clear) begin
          $error("zone_clear: expected %0d, actual %0d", want_v.zone_clear, got_v.zone_clear);
          fail_count++;
        end
        if (got_v.oz_sum !== want_v.oz_sum) begin
          $error("out_zone_sum: expected %0d, actual %0d",
                 $signed(want_v.oz_sum), $signed(got_v.oz_sum));
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed pairs, random phases, a calm tail.
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < NUM_DIRECTED; k++) begin
      if (DIRECTED_PAIRS[k].len_cfg != seq_len_reg) set_length(DIRECTED_PAIRS[k].len_cfg);
      push_pair(DIRECTED_PAIRS[k].seq_a, DIRECTED_PAIRS[k].seq_b,
                DIRECTED_PAIRS[k].has_verdict, DIRECTED_PAIRS[k].verdict);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 5;
        default: src_gap_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 5;
        default: sink_stall_pct = 25;
      endcase
      run_phase(p < 12 ? PHASE_LENGTHS[p] : CFG_W'($urandom_range(5, 63)), PHASE_PAIRS);
    end

    // Back-to-back traffic at full length with no idling on either side.
    src_gap_pct = 0;
    sink_stall_pct = 0;
    run_phase(7'd64, CALM_PAIRS);

    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### zcz_pair_checker_top.f
rtl/zcz_pkg.sv
rtl/zcz_pair_checker_top.sv
tb/zcz_pair_checker_top_tb.sv
